// ===== src/multi_bank_clock_step_divider_macros.svh =====
// assertion macros used by the clock step divider datapath
`ifndef MULTI_BANK_CLOCK_STEP_DIVIDER_MACROS_SVH
`define MULTI_BANK_CLOCK_STEP_DIVIDER_MACROS_SVH

// same-cycle implication, checked outside reset
`define MBCSD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mbcsd assertion failed");

// next-cycle implication, checked outside reset
`define MBCSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mbcsd assertion failed");

`endif

// ===== src/mbcsd_pkg.sv =====
// types, constants and tables of the clock step divider
`timescale 1ns / 1ps
package mbcsd_pkg;

  localparam int BANK_COUNT  = 4;
  localparam int HW_BANKS    = 4;
  localparam int NUM_BANKS   = (BANK_COUNT < HW_BANKS) ? BANK_COUNT : HW_BANKS;
  localparam int BANK_W      = 2;
  localparam int COUNT_W     = 32;
  localparam int BPM_W       = 16;
  localparam int ACC_W       = 9;
  localparam int ELAPSED_W   = 5;
  localparam int ELAPSED_CAP = 24;
  localparam int DEFAULT_BPM = 120;
  localparam int MAX_OUT     = 48;
  localparam int OUT_CNT_W   = 6;
  localparam int CODE_W      = 4;
  localparam int MAX_CODE    = 8;
  localparam int US_NUMERATOR = 2500000;
  localparam int NUM_W       = 30;
  localparam int DIV_CNT_W   = $clog2(NUM_W);
  localparam int LEN_W       = 32;
  localparam int EN_W        = HW_BANKS;
  localparam int DIVS_W      = HW_BANKS * CODE_W;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_FIELD_W = BANK_W + LEN_W + COUNT_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLED_BANKS  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_BANK_DIVISIONS = CFG_INDEX_W'(1);
  localparam logic [DIVS_W-1:0]      DIVISIONS_RESET    = DIVS_W'(17476);

  typedef struct packed {
    logic capture;
    logic start;
    logic bank_add;
    logic bank_next;
    logic emit;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic same_count;
    logic bank_en;
    logic last_bank;
    logic div_busy;
    logic step_ok;
    logic pend_valid;
    logic out_free;
  } dp_status_t;

  function automatic logic [ACC_W-1:0] ticks_for_code(input logic [CODE_W-1:0] code);
    logic [ACC_W-1:0] t;
    case (code)
      4'd0:    t = ACC_W'(384);
      4'd1:    t = ACC_W'(192);
      4'd2:    t = ACC_W'(96);
      4'd3:    t = ACC_W'(48);
      4'd4:    t = ACC_W'(24);
      4'd5:    t = ACC_W'(12);
      4'd6:    t = ACC_W'(6);
      4'd7:    t = ACC_W'(3);
      default: t = ACC_W'(2);
    endcase
    return t;
  endfunction

  // microseconds per minute of one tick-step numerator, 2500000 times ticks
  function automatic logic [NUM_W-1:0] numer_for_code(input logic [CODE_W-1:0] code);
    logic [NUM_W-1:0] n;
    case (code)
      4'd0:    n = NUM_W'(US_NUMERATOR * 384);
      4'd1:    n = NUM_W'(US_NUMERATOR * 192);
      4'd2:    n = NUM_W'(US_NUMERATOR * 96);
      4'd3:    n = NUM_W'(US_NUMERATOR * 48);
      4'd4:    n = NUM_W'(US_NUMERATOR * 24);
      4'd5:    n = NUM_W'(US_NUMERATOR * 12);
      4'd6:    n = NUM_W'(US_NUMERATOR * 6);
      4'd7:    n = NUM_W'(US_NUMERATOR * 3);
      default: n = NUM_W'(US_NUMERATOR * 2);
    endcase
    return n;
  endfunction

endpackage

// ===== src/mbcsd_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module mbcsd_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mbcsd_pkg::NUM_W-1:0] numer,
  input  logic [mbcsd_pkg::BPM_W-1:0] denom,
  output logic                        busy,
  output logic [mbcsd_pkg::NUM_W-1:0] quotient
);
  import mbcsd_pkg::*;

  logic [NUM_W-1:0]     quo;
  logic [BPM_W-1:0]     rem;
  logic [BPM_W-1:0]     den;
  logic [DIV_CNT_W-1:0] cnt;
  logic [BPM_W:0]       shifted;
  logic [BPM_W:0]       diff;
  logic                 ge;

  assign shifted  = {rem, quo[NUM_W-1]};
  assign diff     = shifted - {1'b0, den};
  assign ge       = ~diff[BPM_W];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(NUM_W - 1);
      quo  <= numer;
      rem  <= '0;
      den  <= denom;
    end else if (busy) begin
      rem <= ge ? diff[BPM_W-1:0] : shifted[BPM_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== src/mbcsd_dp.sv =====
// datapath: config registers, accumulators, divider, pending and output registers
`timescale 1ns / 1ps
`include "multi_bank_clock_step_divider_macros.svh"
module mbcsd_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  mbcsd_pkg::dp_cmd_t                cmd,
  output mbcsd_pkg::dp_status_t             st,
  input  logic [mbcsd_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                              cfg_valid,
  input  logic [mbcsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mbcsd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mbcsd_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                              m_tlast
);
  import mbcsd_pkg::*;

  logic [EN_W-1:0]        enabled;
  logic [DIVS_W-1:0]      divisions;
  logic [COUNT_W-1:0]     previous_count;
  logic [ACC_W-1:0]       acc [HW_BANKS];
  logic [COUNT_W-1:0]     now;
  logic [BPM_W-1:0]       bpm;
  logic [ELAPSED_W-1:0]   elapsed;
  logic [BANK_W-1:0]      bank;
  logic [ACC_W-1:0]       divisor;
  logic [OUT_CNT_W-1:0]   out_count;
  logic                   pend_valid;
  logic [OUT_FIELD_W-1:0] pend_data;
  logic [OUT_FIELD_W-1:0] out_data;

  logic [COUNT_W-1:0]     diff;
  logic [CODE_W-1:0]      code;
  logic [ACC_W-1:0]       acc_cur;
  logic                   out_free;
  logic                   div_busy;
  logic [NUM_W-1:0]       quotient;
  logic [COUNT_W-1:0]     tick;
  logic [EN_W-1:0]        rising;

  assign diff     = now - previous_count;
  assign code     = divisions[{bank, 2'b00} +: CODE_W];
  assign acc_cur  = acc[bank];
  assign out_free = ~m_tvalid | m_tready;
  assign tick     = now - COUNT_W'(acc_cur);
  assign rising   = cfg_data[EN_W-1:0] & ~enabled;

  assign st.same_count = (now == previous_count);
  assign st.bank_en    = enabled[bank];
  assign st.last_bank  = (bank == BANK_W'(NUM_BANKS - 1));
  assign st.div_busy   = div_busy;
  assign st.step_ok    = (acc_cur >= divisor) && (out_count < OUT_CNT_W'(MAX_OUT));
  assign st.pend_valid = pend_valid;
  assign st.out_free   = out_free;

  assign m_tdata = {(OUT_DATA_W - OUT_FIELD_W)'(0), out_data};

  mbcsd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.bank_add),
    .numer    (numer_for_code(code)),
    .denom    (bpm),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled        <= '0;
      divisions      <= DIVISIONS_RESET;
      previous_count <= '0;
      for (int i = 0; i < HW_BANKS; i++) begin
        acc[i] <= '0;
      end
      bank       <= '0;
      out_count  <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
      m_tlast    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_ENABLED_BANKS: begin
            enabled <= cfg_data[EN_W-1:0];
            for (int i = 0; i < HW_BANKS; i++) begin
              if (rising[i]) begin
                acc[i] <= '0;
              end
            end
          end
          CFG_BANK_DIVISIONS: divisions <= cfg_data[DIVS_W-1:0];
          default: ;
        endcase
      end
      if (cmd.capture) begin
        now <= s_tdata[COUNT_W-1:0];
        bpm <= (s_tdata[IN_DATA_W-1:COUNT_W] == '0) ? BPM_W'(DEFAULT_BPM)
                                                    : s_tdata[IN_DATA_W-1:COUNT_W];
      end
      if (cmd.start) begin
        previous_count <= now;
        elapsed   <= (diff > COUNT_W'(ELAPSED_CAP)) ? ELAPSED_W'(ELAPSED_CAP)
                                                     : diff[ELAPSED_W-1:0];
        bank      <= '0;
        out_count <= '0;
      end
      if (cmd.bank_next) begin
        bank <= bank + 1'b1;
      end
      if (cmd.bank_add) begin
        acc[bank] <= acc_cur + ACC_W'(elapsed);
        divisor   <= ticks_for_code(code);
      end
      if (cmd.emit || cmd.flush) begin
        if (pend_valid) begin
          out_data <= pend_data;
          m_tlast  <= cmd.flush;
          m_tvalid <= 1'b1;
        end else if (m_tready) begin
          m_tvalid <= 1'b0;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.emit) begin
        pend_data  <= {tick, LEN_W'(quotient), bank};
        pend_valid <= 1'b1;
        acc[bank]  <= acc_cur - divisor;
        out_count  <= out_count + 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  `MBCSD_ASSERT_IMPL(a_count_cap, 1'b1, out_count <= OUT_CNT_W'(MAX_OUT))
  `MBCSD_ASSERT_IMPL(a_emit_room, (cmd.emit || cmd.flush) && pend_valid, out_free)
  `MBCSD_ASSERT_IMPL(a_emit_ok, cmd.emit, st.step_ok && !div_busy)
  `MBCSD_ASSERT_NEXT(a_div_runs, cmd.bank_add, div_busy)

endmodule

// ===== src/mbcsd_ctrl.sv =====
// controller state machine sequencing banks, division and steps
`timescale 1ns / 1ps
module mbcsd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  mbcsd_pkg::dp_status_t st,
  output mbcsd_pkg::dp_cmd_t    cmd
);
  import mbcsd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_BANK,
    S_DIVIDE,
    S_STEP,
    S_FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.same_count) begin
          state_next = S_IDLE;
        end else begin
          cmd.start  = 1'b1;
          state_next = S_BANK;
        end
      end
      S_BANK: begin
        if (st.bank_en) begin
          cmd.bank_add = 1'b1;
          state_next   = S_DIVIDE;
        end else if (st.last_bank) begin
          state_next = S_FLUSH;
        end else begin
          cmd.bank_next = 1'b1;
        end
      end
      S_DIVIDE: begin
        if (!st.div_busy) begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (st.step_ok) begin
          cmd.emit = !st.pend_valid || st.out_free;
        end else if (st.last_bank) begin
          state_next = S_FLUSH;
        end else begin
          cmd.bank_next = 1'b1;
          state_next    = S_BANK;
        end
      end
      S_FLUSH: begin
        if (!st.pend_valid) begin
          state_next = S_IDLE;
        end else if (st.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      s_tready <= 1'b1;
    end else begin
      state    <= state_next;
      s_tready <= (state_next == S_IDLE);
    end
  end

endmodule

// ===== src/multi_bank_clock_step_divider.sv =====
// top level of the multi-bank clock step divider
// Usage:
// - slave stream takes one clock report per transfer: tick count and tempo.
//   s_tready is high only while no report is in work.
// - a report whose count equals the previous one makes no output;
//   otherwise every enabled bank gets the elapsed ticks (capped at 24)
//   and fires a step transfer per full divisor held, up to 48 per report.
// - per enabled bank one 30-bit quotient of the step length is formed by a
//   one-bit-per-cycle divider before that bank's steps are fired.
// - the last step of a report carries m_tlast.
// - a stalled master side holds one output and one pending step; the engine
//   waits on further steps and resumes when m_tready returns.
// - cfg writes are always taken; write only while no report is in work.
// - synchronous reset clears counts, accumulators, enables and sets all
//   division codes to quarter notes.
`timescale 1ns / 1ps
module multi_bank_clock_step_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // clock_count [31:0], tempo_bpm [47:32]
  input  logic [mbcsd_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // bank_number [1:0], step_length_us [33:2], step_tick [65:34], zero fill
  output logic [mbcsd_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mbcsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mbcsd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mbcsd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  mbcsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  mbcsd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
